// ----- hw/rtl/epe_pkg.sv -----
// shared types, codes and field widths of the event packet expander
package epe_pkg;

  localparam int WordW   = 16;
  localparam int TimeW   = 32;
  localparam int KeyW    = 32;
  localparam int PayW    = 32;
  localparam int StatusW = 3;
  localparam int CountW  = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 48;
  localparam int OutDataW = 64;
  localparam int OutUserW = 4;

  // result status codes
  localparam logic [StatusW-1:0] ST_SENT    = 3'd0;
  localparam logic [StatusW-1:0] ST_REJECT  = 3'd1;
  localparam logic [StatusW-1:0] ST_FUTURE  = 3'd2;
  localparam logic [StatusW-1:0] ST_LATE    = 3'd3;
  localparam logic [StatusW-1:0] ST_COMMAND = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_USE_CFG_PREFIX = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_PREFIX     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PREFIX_SHIFT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CHECK_KEYS     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_REGION     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_KEY_MASK       = 3'd5;

  // packet types from header bits 11:10
  localparam logic [1:0] TYPE_K16   = 2'd0;
  localparam logic [1:0] TYPE_K16P  = 2'd1;
  localparam logic [1:0] TYPE_K32   = 2'd2;
  localparam logic [1:0] TYPE_K32P  = 2'd3;

  typedef struct packed {
    logic            use_cfg_prefix;
    logic [KeyW-1:0] key_prefix;
    logic [4:0]      prefix_shift;
    logic            check_keys;
    logic [KeyW-1:0] key_region;
    logic [KeyW-1:0] key_mask;
  } cfg_t;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PayW-1:0]    payload;
    logic               pay_flag;
    logic [StatusW-1:0] status;
  } result_t;

  // packet parser phases, one-hot
  typedef enum logic [4:0] {
    PH_HEADER     = 5'b00001,
    PH_KEY_PREFIX = 5'b00010,
    PH_PAY_PREFIX = 5'b00100,
    PH_EVENTS     = 5'b01000,
    PH_SKIP       = 5'b10000
  } phase_t;

endpackage

// ----- hw/rtl/event_packet_expander_core.sv -----
// top level of the event packet expander
//
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  tdata: word[15:0], current_time[47:16]; tlast: last_word
// m_*       out  m_tvalid/m_tready  tdata: key[31:0], payload[63:32];
//                                   tuser: pay_flag[0], status[3:1]
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// one packet word is taken per cycle while s_tready is high; each word is
// decoded and its result registered in the same cycle into the result buffer.
// rst is synchronous and returns the parser to expecting a header word.
// a two-entry result buffer lets one more word in while a result waits;
// s_tready drops only when both entries are held and m_tready is low.
module event_packet_expander_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [epe_pkg::InDataW-1:0]    s_tdata,   // word[15:0], current_time[47:16]
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [epe_pkg::OutDataW-1:0]   m_tdata,   // key[31:0], payload[63:32]
  output logic [epe_pkg::OutUserW-1:0]   m_tuser,   // pay_flag[0], status[3:1]
  input  logic                           cfg_we,
  input  logic [epe_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [epe_pkg::CfgDataW-1:0]   cfg_data
);

  epe_pkg::cfg_t    cfg;
  epe_pkg::result_t res, out_res;
  logic             res_valid;
  logic             accept;
  logic             can_take;

  assign s_tready = can_take;
  assign accept   = s_tvalid && can_take;

  // configuration registers
  epe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // packet parser
  epe_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .word         (s_tdata[15:0]),
    .last_word    (s_tlast),
    .current_time (s_tdata[47:16]),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result buffer
  epe_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.payload, out_res.key};
  assign m_tuser = {out_res.status, out_res.pay_flag};

endmodule

// ----- hw/rtl/epe_cfg_regs.sv -----
// configuration register file of the event packet expander
module epe_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [epe_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [epe_pkg::CfgDataW-1:0]  cfg_data,
  output epe_pkg::cfg_t                 cfg
);

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        epe_pkg::REG_USE_CFG_PREFIX: cfg.use_cfg_prefix <= cfg_data[0];
        epe_pkg::REG_KEY_PREFIX:     cfg.key_prefix     <= cfg_data;
        epe_pkg::REG_PREFIX_SHIFT:   cfg.prefix_shift   <= cfg_data[4:0];
        epe_pkg::REG_CHECK_KEYS:     cfg.check_keys     <= cfg_data[0];
        epe_pkg::REG_KEY_REGION:     cfg.key_region     <= cfg_data;
        epe_pkg::REG_KEY_MASK:       cfg.key_mask       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/epe_parser.sv -----
// packet parser: header, prefixes, event assembly, key filter, status
module epe_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  epe_pkg::cfg_t               cfg,
  input  logic                        accept,
  input  logic [epe_pkg::WordW-1:0]   word,
  input  logic                        last_word,
  input  logic [epe_pkg::TimeW-1:0]   current_time,
  output logic                        res_valid,
  output epe_pkg::result_t            res
);

  epe_pkg::phase_t              phase, phase_next;
  logic                         hb_f, hb_f_next;
  logic                         hb_d, hb_d_next;
  logic                         hb_t, hb_t_next;
  logic [1:0]                   ptype, ptype_next;
  logic [epe_pkg::CountW-1:0]   events_left, events_left_next;
  logic [epe_pkg::KeyW-1:0]     key_pfx, key_pfx_next;
  logic [epe_pkg::PayW-1:0]     pay_pfx, pay_pfx_next;
  logic [47:0]                  partial, partial_next;
  logic [1:0]                   wie, wie_next;

  // per-word work of the current phase
  always_comb begin
    logic                       do_after;
    logic                       last_of_event;
    logic [epe_pkg::WordW-1:0]  w0, w1, w2, w3;
    logic [epe_pkg::KeyW-1:0]   key;
    logic [epe_pkg::PayW-1:0]   pay;
    logic [epe_pkg::CountW-1:0] ev_dec;

    phase_next       = phase;
    hb_f_next        = hb_f;
    hb_d_next        = hb_d;
    hb_t_next        = hb_t;
    ptype_next       = ptype;
    events_left_next = events_left;
    key_pfx_next     = key_pfx;
    pay_pfx_next     = pay_pfx;
    partial_next     = partial;
    wie_next         = wie;
    res_valid        = 1'b0;
    res              = '0;
    do_after         = 1'b0;
    last_of_event    = 1'b0;
    w0 = partial[15:0];
    w1 = partial[31:16];
    w2 = partial[47:32];
    w3 = word;
    key = '0;
    pay = '0;
    ev_dec = events_left - epe_pkg::CountW'(1);

    unique case (phase)
      epe_pkg::PH_HEADER: begin
        if (word == '0) begin
          phase_next = epe_pkg::PH_SKIP;
        end else if (word[15:14] == 2'b01) begin
          // command packet
          phase_next = epe_pkg::PH_SKIP;
          res_valid  = 1'b1;
          res.status = epe_pkg::ST_COMMAND;
        end else begin
          hb_f_next        = word[14];
          hb_d_next        = word[13];
          hb_t_next        = word[12];
          ptype_next       = word[11:10];
          events_left_next = word[7:0];
          key_pfx_next     = cfg.key_prefix;
          pay_pfx_next     = '0;
          if (!word[15] && cfg.use_cfg_prefix) begin
            hb_f_next = (cfg.prefix_shift == '0);
          end
          wie_next     = '0;
          partial_next = '0;
          if (word[15]) begin
            phase_next = epe_pkg::PH_KEY_PREFIX;
          end else if (word[13]) begin
            phase_next = epe_pkg::PH_PAY_PREFIX;
          end else begin
            do_after = 1'b1;
          end
        end
      end
      epe_pkg::PH_KEY_PREFIX: begin
        key_pfx_next = hb_f ? {word, 16'h0000} : {16'h0000, word};
        if (hb_d) begin
          phase_next = epe_pkg::PH_PAY_PREFIX;
        end else begin
          do_after = 1'b1;
        end
      end
      epe_pkg::PH_PAY_PREFIX: begin
        if (ptype[1]) begin
          if (wie == 2'd0) begin
            pay_pfx_next = {16'h0000, word};
            wie_next     = 2'd1;
          end else begin
            pay_pfx_next = {word, pay_pfx[15:0]};
            do_after     = 1'b1;
          end
        end else begin
          pay_pfx_next = {16'h0000, word};
          do_after     = 1'b1;
        end
      end
      epe_pkg::PH_EVENTS: begin
        // a word closes the event when it is the last one the type needs
        unique case (ptype)
          epe_pkg::TYPE_K16:  last_of_event = 1'b1;
          epe_pkg::TYPE_K16P: last_of_event = (wie == 2'd1);
          epe_pkg::TYPE_K32:  last_of_event = (wie == 2'd1);
          epe_pkg::TYPE_K32P: last_of_event = (wie == 2'd3);
          default:            last_of_event = 1'b1;
        endcase
        if (!last_of_event) begin
          unique case (wie)
            2'd0:    partial_next[15:0]  = word;
            2'd1:    partial_next[31:16] = word;
            default: partial_next[47:32] = word;
          endcase
          wie_next = wie + 2'd1;
        end else begin
          unique case (ptype)
            epe_pkg::TYPE_K16: begin
              key = {16'h0000, word};
              pay = '0;
            end
            epe_pkg::TYPE_K16P: begin
              key = {16'h0000, w0};
              pay = {16'h0000, word};
            end
            epe_pkg::TYPE_K32: begin
              key = {word, w0};
              pay = '0;
            end
            default: begin
              key = {w1, w0};
              pay = {w3, w2};
            end
          endcase
          if (!hb_f) begin
            key = {key[15:0], 16'h0000};
          end
          key = key | key_pfx;
          pay = pay | pay_pfx;
          wie_next         = '0;
          partial_next     = '0;
          events_left_next = ev_dec;
          if (ev_dec == '0) begin
            phase_next = epe_pkg::PH_SKIP;
          end
          res_valid = 1'b1;
          res.key   = key;
          if (cfg.check_keys && ((key & cfg.key_mask) != cfg.key_region)) begin
            res.status = epe_pkg::ST_REJECT;
          end else begin
            res.status   = epe_pkg::ST_SENT;
            res.pay_flag = ptype[0] && !hb_t;
            res.payload  = (ptype[0] && !hb_t) ? pay : '0;
          end
        end
      end
      epe_pkg::PH_SKIP: ;
      default: phase_next = epe_pkg::PH_HEADER;
    endcase

    // end of prefixes: timestamp decision or start of events
    if (do_after) begin
      wie_next     = '0;
      partial_next = '0;
      if (ptype_next[0] && hb_t_next && (pay_pfx_next != current_time)) begin
        phase_next = epe_pkg::PH_SKIP;
        res_valid  = 1'b1;
        res.status = (pay_pfx_next > current_time) ? epe_pkg::ST_FUTURE
                                                   : epe_pkg::ST_LATE;
      end else begin
        phase_next = (events_left_next != '0) ? epe_pkg::PH_EVENTS : epe_pkg::PH_SKIP;
      end
    end

    // last word of a packet: next word is a header
    if (last_word) begin
      phase_next       = epe_pkg::PH_HEADER;
      events_left_next = '0;
      wie_next         = '0;
      partial_next     = '0;
    end

    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  // parser state, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= epe_pkg::PH_HEADER;
      hb_f        <= 1'b0;
      hb_d        <= 1'b0;
      hb_t        <= 1'b0;
      ptype       <= '0;
      events_left <= '0;
      key_pfx     <= '0;
      pay_pfx     <= '0;
      partial     <= '0;
      wie         <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      hb_f        <= hb_f_next;
      hb_d        <= hb_d_next;
      hb_t        <= hb_t_next;
      ptype       <= ptype_next;
      events_left <= events_left_next;
      key_pfx     <= key_pfx_next;
      pay_pfx     <= pay_pfx_next;
      partial     <= partial_next;
      wie         <= wie_next;
    end
  end

endmodule

// ----- hw/rtl/epe_out_buf.sv -----
// two-entry result buffer between parser and output stream
module epe_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  epe_pkg::result_t push_data,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output epe_pkg::result_t out_data
);

  logic             valid0, valid1;
  epe_pkg::result_t data0, data1;
  logic             pop;

  assign pop       = valid0 && out_ready;
  assign out_valid = valid0;
  assign out_data  = data0;
  assign can_take  = !valid1 || out_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else if (pop) begin
      if (valid1) begin
        valid1 <= push;
      end else begin
        valid0 <= push;
      end
    end else if (push) begin
      if (valid0) begin
        valid1 <= 1'b1;
      end else begin
        valid0 <= 1'b1;
      end
    end
  end

  // entry data
  always_ff @(posedge clk) begin
    if (pop) begin
      if (valid1) begin
        data0 <= data1;
        if (push) begin
          data1 <= push_data;
        end
      end else if (push) begin
        data0 <= push_data;
      end
    end else if (push) begin
      if (valid0) begin
        data1 <= push_data;
      end else begin
        data0 <= push_data;
      end
    end
  end

endmodule
